### rtl/slcp_pkg.sv
package slcp_pkg;

    localparam int ADDR_W               = 64;
    localparam int COUNT_W              = 32;
    localparam int NUM_SETS_DEF         = 64;
    localparam int NUM_WAYS_DEF         = 8;
    localparam int LINE_OFFSET_BITS_DEF = 6;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // one lookup retiring into the statistics counters
    typedef struct packed {
        logic en;
        logic hit;
    } slcp_update_t;

endpackage

### rtl/slcp_ram.sv
// generic single-write, single-read RAM, registered read
module slcp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/slcp_lookup.sv
// tag compare against one set row and LRU reorder of that row
module slcp_lookup #(
    parameter int NUM_WAYS = 8,
    parameter int TAG_W    = 52
) (
    input  logic [NUM_WAYS*TAG_W-1:0] row_tags,
    input  logic [NUM_WAYS-1:0]       row_valid,
    input  logic [TAG_W-1:0]          tag,
    output logic                      hit,
    output logic [NUM_WAYS*TAG_W-1:0] new_tags,
    output logic [NUM_WAYS-1:0]       new_valid
);

    logic [NUM_WAYS-1:0] match;
    logic [NUM_WAYS-1:0] shift_en;

    always_comb
    begin
        logic seen;
        seen = 1'b0;
        for (int k = 0; k < NUM_WAYS; k++)
        begin
            match[k] = row_valid[k] && (row_tags[k*TAG_W +: TAG_W] == tag);
        end
        hit = |match;
        // position k takes k-1 when k is at the hit position or on its
        // more-recent side; on a miss every position shifts
        for (int k = 0; k < NUM_WAYS; k++)
        begin
            shift_en[k] = !hit || !seen;
            seen        = seen || match[k];
        end
    end

    always_comb
    begin
        new_tags[0 +: TAG_W] = tag;
        new_valid[0]         = 1'b1;
        for (int k = 1; k < NUM_WAYS; k++)
        begin
            new_tags[k*TAG_W +: TAG_W] = shift_en[k] ? row_tags[(k-1)*TAG_W +: TAG_W]
                                                     : row_tags[k*TAG_W +: TAG_W];
            new_valid[k] = hit ? row_valid[k] : row_valid[k-1];
        end
    end

endmodule

### rtl/slcp_counters.sv
// saturating hit and miss counters
module slcp_counters (
    input  logic                          clk,
    input  logic                          rst_n,
    input  slcp_pkg::slcp_update_t        upd,
    output logic [slcp_pkg::COUNT_W-1:0]  hit_count,
    output logic [slcp_pkg::COUNT_W-1:0]  miss_count
);

    logic [slcp_pkg::COUNT_W-1:0] hits_reg;
    logic [slcp_pkg::COUNT_W-1:0] hits_next;
    logic [slcp_pkg::COUNT_W-1:0] misses_reg;
    logic [slcp_pkg::COUNT_W-1:0] misses_next;

    always_comb
    begin
        hits_next   = hits_reg;
        misses_next = misses_reg;
        if (upd.en && upd.hit && (hits_reg != slcp_pkg::COUNT_MAX))
        begin
            hits_next = hits_reg + 1'b1;
        end
        if (upd.en && !upd.hit && (misses_reg != slcp_pkg::COUNT_MAX))
        begin
            misses_next = misses_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hits_reg   <= '0;
            misses_reg <= '0;
        end
        else
        begin
            hits_reg   <= hits_next;
            misses_reg <= misses_next;
        end
    end

    assign hit_count  = hits_reg;
    assign miss_count = misses_reg;

endmodule

### rtl/set_associative_lru_cache_profiler.sv
// Flow: one address at a time; a new address is taken only after the read-modify-write
//   of its set row in the tag RAM (read issued on transfer, row written back next cycle)
//   ends and the result slot is free; hit and out_valid are registered in the lookup cycle.
// Reset: asynchronous, active low. A clearing pass then zeroes the valid bits of every
//   row, one set after another; no address is taken until it ends.
module set_associative_lru_cache_profiler #(
    parameter int NUM_SETS         = slcp_pkg::NUM_SETS_DEF,        // power of two
    parameter int NUM_WAYS         = slcp_pkg::NUM_WAYS_DEF,
    parameter int LINE_OFFSET_BITS = slcp_pkg::LINE_OFFSET_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [slcp_pkg::ADDR_W-1:0]   address,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          hit,
    output logic [slcp_pkg::COUNT_W-1:0]  hit_count,
    output logic [slcp_pkg::COUNT_W-1:0]  miss_count
);

    // address split: | tag | set index | line offset |
    localparam int SET_BITS = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 0;
    localparam int IDX_W    = (SET_BITS > 0) ? SET_BITS : 1;
    localparam int TAG_W    = slcp_pkg::ADDR_W - LINE_OFFSET_BITS - SET_BITS;
    // one RAM row per set: valid bits on top, tags below, position 0 most recent
    localparam int TAGS_W   = NUM_WAYS * TAG_W;
    localparam int ROW_W    = TAGS_W + NUM_WAYS;

    typedef enum logic [2:0] {
        ST_CLEAR  = 3'b001,
        ST_IDLE   = 3'b010,
        ST_LOOKUP = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [IDX_W-1:0] clr_cnt_reg;
    logic [IDX_W-1:0] clr_cnt_next;
    logic             out_valid_reg;
    logic             out_valid_next;

    // payload of the address in flight, no reset needed
    logic [TAG_W-1:0] tag_reg;
    logic [IDX_W-1:0] set_reg;
    logic             hit_reg;

    logic             in_xfer;
    logic             out_xfer;
    logic             clr_done;
    logic [IDX_W-1:0] in_set;

    // RAM ports
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [ROW_W-1:0] ram_wdata;
    logic [ROW_W-1:0] ram_rdata;

    // lookup results
    logic                lk_hit;
    logic [TAGS_W-1:0]   lk_tags;
    logic [NUM_WAYS-1:0] lk_valid;

    slcp_pkg::slcp_update_t upd;

    assign out_xfer = out_valid_reg && !out_stall;
    // one address at a time; the result slot must be free by the lookup cycle
    assign in_stall = !((state_reg == ST_IDLE) && (!out_valid_reg || !out_stall));
    assign in_xfer  = in_valid && !in_stall;
    assign clr_done = (clr_cnt_reg == IDX_W'(NUM_SETS - 1));
    assign in_set   = (SET_BITS == 0) ? '0 : address[LINE_OFFSET_BITS +: IDX_W];

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (state_reg == ST_LOOKUP)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_xfer)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            tag_reg <= address[slcp_pkg::ADDR_W-1 -: TAG_W];
            set_reg <= in_set;
        end
        if (state_reg == ST_LOOKUP)
        begin
            hit_reg <= lk_hit;
        end
    end

    // write port: zero rows during the clearing pass, write back the
    // reordered row in the lookup cycle
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = set_reg;
        ram_wdata = {lk_valid, lk_tags};
        if (state_reg == ST_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg;
            ram_wdata = '0;
        end
        else if (state_reg == ST_LOOKUP)
        begin
            ram_we = 1'b1;
        end
    end

    slcp_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_SETS),
        .AW    (IDX_W)
    ) u_tag_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (in_xfer),
        .raddr (in_set),
        .rdata (ram_rdata)
    );

    slcp_lookup #(
        .NUM_WAYS (NUM_WAYS),
        .TAG_W    (TAG_W)
    ) u_lookup (
        .row_tags  (ram_rdata[TAGS_W-1:0]),
        .row_valid (ram_rdata[ROW_W-1 -: NUM_WAYS]),
        .tag       (tag_reg),
        .hit       (lk_hit),
        .new_tags  (lk_tags),
        .new_valid (lk_valid)
    );

    assign upd.en  = (state_reg == ST_LOOKUP);
    assign upd.hit = lk_hit;

    // counters only move in the lookup cycle, so they hold while a result stalls
    slcp_counters u_counters (
        .clk        (clk),
        .rst_n      (rst_n),
        .upd        (upd),
        .hit_count  (hit_count),
        .miss_count (miss_count)
    );

    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;

endmodule
